[src/ift_pkg.sv]
package ift_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 63;

    localparam int VAL_W  = 32;                 // argument width
    localparam int NDIG   = 10;                 // decimal digits of a 32-bit value
    localparam int BCD_W  = 4 * NDIG;           // digit shift register
    localparam int ND_W   = $clog2(NDIG + 1);   // digit count
    localparam int CNT_W  = $clog2(VAL_W);      // double-dabble bit counter
    localparam int WID_W  = 6;                  // field width
    localparam int CHAR_W = 8;

    typedef enum logic [1:0] {
        OP_SDEC = 2'd0,
        OP_UDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_DABBLE,
        CV_STRIP,
        CV_DONE
    } t_cv_state;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // converted field handed from the converter to the emitter
    typedef struct packed {
        logic [BCD_W-1:0] dig;   // most significant digit in the top nibble
        logic [ND_W-1:0]  nd;    // significant digits, at least one
        logic             neg;
        logic             zp;
        logic [WID_W-1:0] w;     // saturated width
    } t_digits;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0000, d};
        end else begin
            c = CH_A + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

[src/ift_conv.sv]
module ift_conv #(
    parameter int unsigned MAX_WIDTH = ift_pkg::DEF_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_op,
    input  logic [31:0]                i_value,
    input  logic [5:0]                 i_width,
    input  logic                       i_zero_pad,
    output logic                       o_dig_valid,
    input  logic                       i_dig_ready,
    output ift_pkg::t_digits           o_dig
);
    import ift_pkg::*;

    localparam logic [7:0] MaxW = 8'(MAX_WIDTH);

    t_cv_state          r_state, n_state;
    logic [VAL_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_dig;
    logic [BCD_W-1:0]   adj;
    logic [CNT_W-1:0]   r_cnt;
    logic [ND_W-1:0]    r_nd;
    logic               r_neg, r_zp;
    logic [WID_W-1:0]   r_w;
    logic               in_neg;
    logic [VAL_W-1:0]   in_mag;
    logic [WID_W-1:0]   in_w;
    logic               strip_go;
    t_op                op;

    assign op       = t_op'(i_op);
    assign in_neg   = (op == OP_SDEC) && i_value[VAL_W-1];
    assign in_mag   = in_neg ? (~i_value + 32'd1) : i_value;
    assign in_w     = ({2'b00, i_width} > MaxW) ? MaxW[WID_W-1:0] : i_width;
    assign strip_go = (r_dig[BCD_W-1 -: 4] == 4'd0) && (r_nd > ND_W'(1));

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_dig[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CV_IDLE: begin
                if (i_valid && (op != OP_NONE)) begin
                    n_state = (op == OP_HEX) ? CV_STRIP : CV_DABBLE;
                end
            end
            CV_DABBLE: begin
                if (r_cnt == CNT_W'(VAL_W - 1)) n_state = CV_STRIP;
            end
            CV_STRIP: begin
                if (!strip_go) n_state = CV_DONE;
            end
            CV_DONE: begin
                if (i_dig_ready) n_state = CV_IDLE;
            end
            default: n_state = CV_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == CV_IDLE);
        o_dig_valid = (r_state == CV_DONE);
        o_dig.dig   = r_dig;
        o_dig.nd    = r_nd;
        o_dig.neg   = r_neg;
        o_dig.zp    = r_zp;
        o_dig.w     = r_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CV_IDLE: begin
                r_bin <= in_mag;
                r_dig <= (op == OP_HEX) ? {{(BCD_W - VAL_W){1'b0}}, in_mag} : '0;
                r_cnt <= '0;
                r_nd  <= ND_W'(NDIG);
                r_neg <= in_neg;
                r_zp  <= i_zero_pad;
                r_w   <= in_w;
            end
            CV_DABBLE: begin
                r_dig <= {adj[BCD_W-2:0], r_bin[VAL_W-1]};
                r_bin <= {r_bin[VAL_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            CV_STRIP: begin
                if (strip_go) begin
                    r_dig <= {r_dig[BCD_W-5:0], 4'd0};
                    r_nd  <= r_nd - ND_W'(1);
                end
            end
            CV_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

[src/ift_emit.sv]
module ift_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_dig_valid,
    output logic                  o_dig_ready,
    input  ift_pkg::t_digits      i_dig,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [7:0]            o_tdata,
    output logic                  o_tlast
);
    import ift_pkg::*;

    logic               r_active;
    logic               r_tvalid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [BCD_W-1:0]   r_dig;
    logic [ND_W-1:0]    r_nd;
    logic               r_sign, r_zp;
    logic [WID_W-1:0]   r_pad;
    logic [WID_W-1:0]   len;
    logic [WID_W-1:0]   pad;
    logic               slot;
    logic [CHAR_W-1:0]  n_char;
    logic               n_last;

    assign len         = WID_W'(i_dig.nd) + WID_W'(i_dig.neg);
    assign pad         = (i_dig.w > len) ? (i_dig.w - len) : '0;
    assign o_dig_ready = !r_active;
    assign slot        = r_active && (!r_tvalid || i_tready);

    // next character: leading sign under zero padding, pad, sign, digits
    always_comb begin
        n_last = 1'b0;
        priority if (r_sign && r_zp) begin
            n_char = CH_MINUS;
        end else if (r_pad != '0) begin
            n_char = r_zp ? CH_ZERO : CH_SPACE;
        end else if (r_sign) begin
            n_char = CH_MINUS;
        end else begin
            n_char = digit_char(r_dig[BCD_W-1 -: 4]);
            n_last = (r_nd == ND_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_dig_valid && !r_active) begin
                r_active <= 1'b1;
            end else if (slot && n_last) begin
                r_active <= 1'b0;
            end
            if (slot) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dig_valid && !r_active) begin
            r_dig  <= i_dig.dig;
            r_nd   <= i_dig.nd;
            r_sign <= i_dig.neg;
            r_zp   <= i_dig.zp;
            r_pad  <= pad;
        end else if (slot) begin
            priority if (r_sign && r_zp) begin
                r_sign <= 1'b0;
            end else if (r_pad != '0) begin
                r_pad <= r_pad - WID_W'(1);
            end else if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_dig <= {r_dig[BCD_W-5:0], 4'd0};
                r_nd  <= r_nd - ND_W'(1);
            end
        end
        if (slot) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_char;
    assign o_tlast  = r_last;

endmodule

[src/integer_field_formatter.sv]
// Channel   Dir  Beat                                         Carries
// s (in)    in   i_s_tvalid / o_s_tready                      one format request
// m (out)   out  o_m_tvalid / i_m_tready                      one character of the field
//
// Steps: accept, double-dabble shift (decimal only), leading-zero strip (one step per digit
// dropped plus a check), hand-off. Then one character per cycle while the output is not
// stalled, max(width, digits + sign) beats, overlapping the next.
// Reset: synchronous, active low; clears converter state and the output valid.
// Stalls: a stalled output holds its beat; the converter waits in its done state.
// Requests with the unused conversion code are taken and dropped.
module integer_field_formatter #(
    parameter int unsigned MAX_WIDTH = ift_pkg::DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // value[31:0], width[37:32], zero_pad[38], zero[39]
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // char_out[7:0]
    output logic        o_m_tlast    // last
);
    import ift_pkg::*;

    logic    dig_valid;
    logic    dig_ready;
    t_digits dig;

    // binary to digits: BCD shift for decimal, then leading-zero strip
    ift_conv #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser),
        .i_value     (i_s_tdata[31:0]),
        .i_width     (i_s_tdata[37:32]),
        .i_zero_pad  (i_s_tdata[38]),
        .o_dig_valid (dig_valid),
        .i_dig_ready (dig_ready),
        .o_dig       (dig)
    );

    // pad / sign / digit sequencer with registered output beat
    ift_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dig_valid (dig_valid),
        .o_dig_ready (dig_ready),
        .i_dig       (dig),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tlast     (o_m_tlast)
    );

    // a real request leaves the converter busy on the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != OP_NONE) |=> !o_s_tready)
        else $error("converter not busy after request");

    // the final character of a field is always a digit
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |->
            ((o_m_tdata >= CH_ZERO) && (o_m_tdata <= CH_NINE)) ||
            ((o_m_tdata >= CH_A) && (o_m_tdata <= CH_F)))
        else $error("last character is not a digit");

    // only sign, pad or digit characters leave the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == CH_MINUS) || (o_m_tdata == CH_SPACE) ||
            ((o_m_tdata >= CH_ZERO) && (o_m_tdata <= CH_NINE)) ||
            ((o_m_tdata >= CH_A) && (o_m_tdata <= CH_F)))
        else $error("illegal output character");

endmodule

[sim/tb_integer_field_formatter.sv]
`timescale 1ns / 100ps

// Checks integer_field_formatter: requests go in on the s stream, characters come
// back on the m stream and are matched one by one, in order, against a queue of
// expected characters built when each request beat is accepted.
module tb_integer_field_formatter;

    import ift_pkg::*;

    // ASCII codes used by the predictor
    localparam logic [7:0] ASC_0     = 8'h30;
    localparam logic [7:0] ASC_A     = 8'h61;   // lower-case 'a'
    localparam logic [7:0] ASC_MINUS = 8'h2d;
    localparam logic [7:0] ASC_SPACE = 8'h20;

    localparam int unsigned MAX_W     = DEF_MAX_WIDTH;
    localparam int          N_RANDOM  = 300;
    localparam int          END_WAIT  = 100;        // > conversion latency, drop path included
    localparam int          CYCLE_CAP = 1_000_000;
    localparam int          PRINT_CAP = 40;

    // one format request, as carried on the s stream
    typedef struct packed {
        t_op         op;
        logic [31:0] val;
        logic [5:0]  w;
        logic        zp;
    } t_fmt_req;

    // one expected character beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_field_char;

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known level
    // ---------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata  = '0;   // value[31:0], width[37:32], zero_pad[38], zero[39]
    logic [1:0]  i_s_tuser  = '0;   // op[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // char_out[7:0]
    logic        o_m_tlast;         // last

    integer_field_formatter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Scoreboard state
    // ---------------------------------------------------------------------
    t_field_char exp_chars [$];     // characters still owed by the DUT, oldest first
    int          mismatches  = 0;
    int          chars_seen  = 0;
    int          fields_seen = 0;
    int          op_count [4] = '{0, 0, 0, 0};
    int          cycles      = 0;
    int          src_gap_max = 7;   // 0 gives back-to-back request beats
    int          sink_gap_max = 7;  // 0 keeps tready high
    int          sink_draw;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0d] MISMATCH: %s", cycles, msg);
    endtask

    // Expected field for one request. Sign goes leftmost under zero padding and
    // right before the digits under space padding; it takes one width slot or
    // widens the field. Zero prints as one '0' in every base, the most negative
    // signed value prints via its unsigned magnitude, op 3 prints nothing.
    function automatic void predict_field(input t_fmt_req r);
        logic [7:0]  digs [$];
        logic [7:0]  line [$];
        logic [31:0] mag;
        logic [3:0]  nib;
        bit          neg;
        int unsigned base, wid, len, pad;
        if (r.op == OP_NONE)
            return;
        wid  = (r.w > MAX_W) ? MAX_W : r.w;
        neg  = (r.op == OP_SDEC) && r.val[31];
        mag  = neg ? 32'd0 - r.val : r.val;
        base = (r.op == OP_HEX) ? 16 : 10;
        do begin
            nib = 4'(mag % base);
            digs.push_front((nib < 4'd10) ? ASC_0 + 8'(nib) : ASC_A + 8'(nib) - 8'd10);
            mag = mag / base;
        end while (mag != 0);
        len = digs.size() + (neg ? 1 : 0);
        pad = (wid > len) ? wid - len : 0;
        if (neg && r.zp)
            line.push_back(ASC_MINUS);
        repeat (pad) line.push_back(r.zp ? ASC_0 : ASC_SPACE);
        if (neg && !r.zp)
            line.push_back(ASC_MINUS);
        foreach (digs[i]) line.push_back(digs[i]);
        while (line.size() > 63) line.pop_back();
        foreach (line[i]) exp_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
    endfunction

    // Drive one request beat and log its expected characters once it is taken.
    // Called right after a rising edge. valid stays high after the beat so that a
    // zero gap gives back-to-back beats without a low glitch.
    task automatic send_req(input t_fmt_req r, input string text);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, r.zp, r.w, r.val};
        i_s_tuser  <= r.op;
        do @(posedge i_clk); while (!o_s_tready);
        op_count[r.op]++;
        if (text.len() != 0) begin
            for (int i = 0; i < text.len(); i++)
                exp_chars.push_back('{ch: text[i], last: (i == text.len() - 1)});
        end else begin
            predict_field(r);
        end
    endtask

    task automatic wait_drained;
        while (exp_chars.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Output side: random stalls per beat, check against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (i_m_tready && o_m_tvalid) begin
            chars_seen++;
            if (exp_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                          o_m_tdata, o_m_tlast));
            end else begin
                if (o_m_tdata !== exp_chars[0].ch)
                    report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                              o_m_tdata, exp_chars[0].ch));
                if (o_m_tlast !== exp_chars[0].last)
                    report_mismatch($sformatf("tlast %0b, expected %0b (char 0x%02h)",
                                              o_m_tlast, exp_chars[0].last, exp_chars[0].ch));
                if (exp_chars[0].last)
                    fields_seen++;
                void'(exp_chars.pop_front());
            end
            sink_draw = $urandom_range(0, sink_gap_max);
            if (sink_draw != 0)
                i_m_tready <= 1'b0;
        end else if (!i_m_tready) begin
            // re-arm after a drawn stall; the draw counts down while tready is low
            if (sink_draw <= 1)
                i_m_tready <= 1'b1;
            else
                sink_draw = sink_draw - 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d chars still owed", cycles, exp_chars.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Directed table: sign placement, padding modes, base extremes, dropped op.
    // Rows with text carry the expected field literally; empty text means the
    // predictor builds it (long fields, dropped requests).
    // ---------------------------------------------------------------------
    localparam int NDIR = 24;

    localparam t_fmt_req DIR_REQ [NDIR] = '{
        '{OP_SDEC, 32'h0000_0000, 6'd0,  1'b0},
        '{OP_UDEC, 32'h0000_0000, 6'd0,  1'b0},
        '{OP_HEX,  32'h0000_0000, 6'd0,  1'b0},
        '{OP_HEX,  32'h0000_0000, 6'd3,  1'b1},
        '{OP_SDEC, 32'h8000_0000, 6'd0,  1'b0},
        '{OP_SDEC, 32'h8000_0000, 6'd12, 1'b1},
        '{OP_UDEC, 32'h8000_0000, 6'd0,  1'b1},
        '{OP_SDEC, 32'h7fff_ffff, 6'd0,  1'b0},
        '{OP_SDEC, 32'hffff_ffff, 6'd0,  1'b1},
        '{OP_UDEC, 32'hffff_ffff, 6'd0,  1'b0},
        '{OP_HEX,  32'hffff_ffff, 6'd0,  1'b0},
        '{OP_SDEC, 32'hffff_ffd6, 6'd6,  1'b1},
        '{OP_SDEC, 32'hffff_ffd6, 6'd6,  1'b0},
        '{OP_SDEC, 32'hffff_ffd6, 6'd2,  1'b1},
        '{OP_UDEC, 32'hffff_ffd6, 6'd6,  1'b1},
        '{OP_HEX,  32'hdead_beef, 6'd10, 1'b0},
        '{OP_HEX,  32'h0000_0abc, 6'd8,  1'b1},
        '{OP_HEX,  32'h0123_4567, 6'd1,  1'b0},
        '{OP_HEX,  32'h0000_000f, 6'd2,  1'b0},
        '{OP_NONE, 32'h0000_04d2, 6'd10, 1'b1},
        '{OP_SDEC, 32'h0000_0000, 6'd63, 1'b0},
        '{OP_SDEC, 32'h8000_0000, 6'd63, 1'b1},
        '{OP_UDEC, 32'd1234567890, 6'd63, 1'b1},
        '{OP_SDEC, 32'hffff_ffff, 6'd63, 1'b0}
    };

    string dir_text [NDIR] = '{
        "0", "0", "0", "000",
        "-2147483648", "-02147483648", "2147483648",
        "2147483647", "-1", "4294967295", "ffffffff",
        "-00042", "   -42", "-42", "4294967254",
        "  deadbeef", "00000abc", "1234567", " f",
        "", "", "", "", ""
    };

    // values weighted toward the interesting corners
    function automatic logic [31:0] pick_value;
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 20);
            1:       v = 32'h8000_0000 + $urandom_range(0, 3) - 32'd1;
            2:       v = 32'hffff_ffff - $urandom_range(0, 300);
            3:       v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mostly short fields, some long, a few at the top of the range
    function automatic logic [5:0] pick_width;
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 6'd63;
        else if (k <= 3)
            return 6'($urandom_range(0, 63));
        else
            return 6'($urandom_range(0, 15));
    endfunction

    initial begin
        t_fmt_req r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NDIR; i++)
            send_req(DIR_REQ[i], dir_text[i]);

        // hold the request side until the directed fields have all come back
        i_s_tvalid <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 25 == 0) begin
                src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
                sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            end
            if (i == N_RANDOM / 2) begin
                i_s_tvalid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            r.op  = ($urandom_range(0, 15) == 0) ? OP_NONE : t_op'($urandom_range(0, 2));
            r.val = pick_value();
            r.w   = pick_width();
            r.zp  = 1'($urandom_range(0, 1));
            send_req(r, "");
        end

        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);

        $display("covered %0d requests: %0d signed, %0d unsigned, %0d hex, %0d dropped",
                 op_count[OP_SDEC] + op_count[OP_UDEC] + op_count[OP_HEX] + op_count[OP_NONE],
                 op_count[OP_SDEC], op_count[OP_UDEC], op_count[OP_HEX], op_count[OP_NONE]);
        $display("checked %0d characters in %0d fields, %0d mismatches",
                 chars_seen, fields_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
src/ift_pkg.sv
src/ift_conv.sv
src/ift_emit.sv
src/integer_field_formatter.sv
sim/tb_integer_field_formatter.sv
